>>> hw/rtl/button_edge_command_encoder_defines.svh
// Assertion macros for the button edge command encoder checker
`ifndef BUTTON_EDGE_COMMAND_ENCODER_DEFINES_SVH
`define BUTTON_EDGE_COMMAND_ENCODER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define BECE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define BECE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/bece_pkg.sv
// Package: types, constants and byte lookup for the button edge command encoder
package bece_pkg;

	localparam int BECE_BTN_W     = 6;
	localparam int BECE_EVT_W     = 7;
	localparam int BECE_PERIOD_W  = 16;
	localparam int BECE_BYTE_W    = 8;
	localparam int BECE_CFG_W     = 16;
	localparam int BECE_IDX_W     = 1;
	localparam int BECE_FIFO_DEPTH = 4;

	localparam logic [BECE_IDX_W-1:0] BECE_REG_PERIOD = 1'b0;
	localparam logic [BECE_IDX_W-1:0] BECE_REG_MASK   = 1'b1;

	localparam logic [BECE_PERIOD_W-1:0] BECE_PERIOD_RESET = 16'd1000;
	localparam logic [BECE_BTN_W-1:0]    BECE_MASK_RESET   = 6'h3F;
	localparam logic [BECE_BTN_W-1:0]    BECE_LEVELS_RESET = 6'h3F;

	localparam logic [BECE_BYTE_W-1:0] BECE_NL   = 8'h0A;
	localparam logic [BECE_BYTE_W-1:0] BECE_CH_D = 8'h44;
	localparam logic [BECE_BYTE_W-1:0] BECE_CH_R = 8'h52;
	localparam logic [BECE_BYTE_W-1:0] BECE_CH_U = 8'h55;
	localparam logic [BECE_BYTE_W-1:0] BECE_CH_L = 8'h4C;
	localparam logic [BECE_BYTE_W-1:0] BECE_CH_A = 8'h41;
	localparam logic [BECE_BYTE_W-1:0] BECE_CH_B = 8'h42;
	localparam logic [BECE_BYTE_W-1:0] BECE_CH_H = 8'h48;

	// event bits in send order: D R U L A B H
	typedef logic [BECE_EVT_W-1:0] bece_evt_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic      avail;
		bece_evt_t evt;
	} bece_head_t;

	// letter for a one-hot event vector
	function automatic logic [BECE_BYTE_W-1:0] bece_letter(input bece_evt_t oh);
		logic [BECE_BYTE_W-1:0] r;
		r = BECE_CH_H;
		unique case (1'b1)
			oh[0]: r = BECE_CH_D;
			oh[1]: r = BECE_CH_R;
			oh[2]: r = BECE_CH_U;
			oh[3]: r = BECE_CH_L;
			oh[4]: r = BECE_CH_A;
			oh[5]: r = BECE_CH_B;
			default: r = BECE_CH_H;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/bece_front.sv
// Front end: config registers, edge detection and heartbeat counting
module bece_front import bece_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [BECE_IDX_W-1:0]   cfg_index,
	input  logic [BECE_CFG_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [BECE_BTN_W-1:0]   buttons,
	input  logic                    tick,
	input  logic                    q_full,
	output logic                    q_push,
	output bece_evt_t               q_evt
);

	logic [BECE_PERIOD_W-1:0] period_q;
	logic [BECE_BTN_W-1:0]    mask_q;
	logic [BECE_BTN_W-1:0]    levels_q;
	logic [BECE_PERIOD_W-1:0] count_q;

	logic [BECE_BTN_W-1:0]    pressed;
	logic [BECE_PERIOD_W:0]   cnt_next;
	logic                     hb_fire;
	logic                     accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign pressed  = levels_q & ~buttons & mask_q;
	assign cnt_next = {1'b0, count_q} + {{BECE_PERIOD_W{1'b0}}, 1'b1};
	assign hb_fire  = tick && (cnt_next >= {1'b0, period_q});

	assign q_evt  = {hb_fire, pressed[5], pressed[4], pressed[3],
		pressed[0], pressed[2], pressed[1]};
	assign q_push = accept && (q_evt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= BECE_PERIOD_RESET;
			mask_q   <= BECE_MASK_RESET;
			levels_q <= BECE_LEVELS_RESET;
			count_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					BECE_REG_PERIOD: period_q <= cfg_data[BECE_PERIOD_W-1:0];
					BECE_REG_MASK:   mask_q   <= cfg_data[BECE_BTN_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				levels_q <= buttons;
				if (tick) begin
					count_q <= hb_fire ? '0 : cnt_next[BECE_PERIOD_W-1:0];
				end
			end
		end
	end

endmodule

>>> hw/rtl/bece_fifo.sv
// Short event queue between front and back ends
module bece_fifo import bece_pkg::*; #(
	parameter int DEPTH = BECE_FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  bece_evt_t  push_evt,
	output logic       full,
	input  logic       pop,
	output bece_head_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bece_evt_t       mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head.avail = (cnt_q != '0);
	assign head.evt   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/bece_back.sv
// Back end: expands event vectors into letter/newline words
module bece_back import bece_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bece_head_t             head,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [BECE_BYTE_W-1:0] byte_res,
	output logic                   last
);

	logic       active_q;
	logic       nl_q;
	bece_evt_t  rem_q;
	logic       out_valid_q;
	logic [BECE_BYTE_W-1:0] byte_q;
	logic       last_q;

	bece_evt_t  sel;
	bece_evt_t  low;
	bece_evt_t  rest;
	logic       have;
	logic       adv;

	assign sel  = active_q ? rem_q : head.evt;
	assign have = active_q || head.avail;
	assign low  = sel & (~sel + 1'b1);
	assign rest = sel & ~low;
	assign adv  = !out_valid_q || out_ready;
	assign pop  = adv && !active_q && head.avail;

	assign out_valid = out_valid_q;
	assign byte_res  = byte_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			nl_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= have;
			if (have) begin
				if (!nl_q) begin
					nl_q     <= 1'b1;
					active_q <= 1'b1;
				end else begin
					nl_q     <= 1'b0;
					active_q <= (rest != '0);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && have) begin
			if (!nl_q) begin
				byte_q <= bece_letter(low);
				last_q <= 1'b0;
				rem_q  <= sel;
			end else begin
				byte_q <= BECE_NL;
				last_q <= (rest == '0);
				rem_q  <= rest;
			end
		end
	end

endmodule

>>> hw/rtl/button_edge_command_encoder.sv
// Top level: button edge command encoder
// An item's first word passes the event queue, then the back end's output register.
// An item with k events (pressed buttons plus heartbeat) gives 2k output words,
// at most 14; the back end's one word per cycle register sets the pace unless stalled.
// Items that send nothing are not queued; input stalls only when the event queue is full.
// Reset: period 1000, all buttons enabled, levels released, tick count and queue cleared.
module button_edge_command_encoder import bece_pkg::*; #(
	parameter int FIFO_DEPTH = BECE_FIFO_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [BECE_IDX_W-1:0]  cfg_index,
	input  logic [BECE_CFG_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [BECE_BTN_W-1:0]  buttons,
	input  logic                   tick,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [BECE_BYTE_W-1:0] byte_res,
	output logic                   last
);

	logic       q_full;
	logic       q_push;
	bece_evt_t  q_evt;
	logic       q_pop;
	bece_head_t q_head;

	bece_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.buttons   (buttons),
		.tick      (tick),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_evt     (q_evt)
	);

	bece_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_evt (q_evt),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head)
	);

	bece_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.byte_res  (byte_res),
		.last      (last)
	);

endmodule

>>> hw/rtl/bece_checker.sv
// Port-level checker for the button edge command encoder, bound to the top level
`include "button_edge_command_encoder_defines.svh"

module bece_checker import bece_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [BECE_BYTE_W-1:0] byte_res,
	input logic                   last
);

	`BECE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(byte_res) && $stable(last), "output word changed while stalled")
	`BECE_ASSERT_NOW(a_last_nl, out_valid && last, byte_res == BECE_NL,
		"last flag on a word other than newline")
	`BECE_ASSERT_NEXT(a_letter_nl, out_valid && out_ready && byte_res != BECE_NL,
		out_valid && byte_res == BECE_NL, "letter not followed at once by newline")
	`BECE_ASSERT_NEXT(a_more_after, out_valid && out_ready && byte_res == BECE_NL && !last,
		out_valid && byte_res != BECE_NL, "no letter after a newline without last")

endmodule

bind button_edge_command_encoder bece_checker u_chk (.*);
